// File: src/srfpll_pkg.sv
// ----------------------------------------------------------------------------
// srfpll_pkg: shared types and constants of the three-phase SRF PLL
// Payload structs, register codes, fixed-point constants and the CORDIC
// arctangent table in fractions of a turn.
// ----------------------------------------------------------------------------
package srfpll_pkg;

   // Sample width of the phase voltages (signed Q.4 volts)
   localparam int SAMPLE_BITS = 16;
   localparam int OUT_BITS    = 16;

   // Shared bit-serial multiplier: multiplicand, multiplier and product widths
   localparam int MUL_A_BITS = SAMPLE_BITS + 29;
   localparam int MUL_B_BITS = 32;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

   // Fixed-point constants
   localparam logic signed [MUL_B_BITS-1:0] ONE_THIRD_Q16  = 32'sd21845;
   localparam logic signed [MUL_B_BITS-1:0] INV_SQRT3_Q16  = 32'sd37837;
   localparam logic signed [MUL_B_BITS-1:0] INV_TWO_PI_Q32 = 32'sd683565276;

   // CORDIC datapath
   localparam int CORDIC_BITS  = 34;
   localparam int CORDIC_STEPS = 16;
   localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   // Register reset values
   localparam logic [23:0] PROP_GAIN_RST     = 24'd3277;
   localparam logic [23:0] INTEG_GAIN_RST    = 24'd163840;
   localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd1678;
   localparam logic [15:0] NOMINAL_FREQ_RST  = 16'd15360;
   localparam logic signed [15:0] COS_ZERO_Q14 = 16'sd16384;

   // Register map (word index)
   typedef enum logic [1:0] {
      REG_PROP_GAIN,
      REG_INTEG_GAIN,
      REG_SAMPLE_PERIOD,
      REG_NOMINAL_FREQ
   } reg_idx_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] phase_a;
      logic signed [SAMPLE_BITS-1:0] phase_b;
      logic signed [SAMPLE_BITS-1:0] phase_c;
   } req_type;

   typedef struct packed {
      logic        [OUT_BITS-1:0] angle;
      logic signed [OUT_BITS-1:0] cos_out;
      logic signed [OUT_BITS-1:0] sin_out;
      logic        [OUT_BITS-1:0] freq_est;
      logic signed [OUT_BITS-1:0] volt_d;
      logic signed [OUT_BITS-1:0] volt_q;
   } rsp_type;

   // Arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [29:0] atan_turn(input logic [3:0] idx);
      logic [29:0] val;
      case (idx)
         4'd0:    val = 30'd536870912;
         4'd1:    val = 30'd316933406;
         4'd2:    val = 30'd167458907;
         4'd3:    val = 30'd85004756;
         4'd4:    val = 30'd42667331;
         4'd5:    val = 30'd21354465;
         4'd6:    val = 30'd10679838;
         4'd7:    val = 30'd5340245;
         4'd8:    val = 30'd2670163;
         4'd9:    val = 30'd1335087;
         4'd10:   val = 30'd667544;
         4'd11:   val = 30'd333772;
         4'd12:   val = 30'd166886;
         4'd13:   val = 30'd83443;
         4'd14:   val = 30'd41722;
         default: val = 30'd20861;
      endcase
      return val;
   endfunction

endpackage

// File: src/three_phase_srf_pll.sv
// ----------------------------------------------------------------------------
// three_phase_srf_pll: three-phase synchronous reference frame PLL
// Clarke and Park transforms, PI loop filter, phase accumulator and CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready) carries one sample of the three phase voltages.
//    req_ready is high only while the loop is idle; one transaction is worked
//    on at a time.
//  - rsp channel (valid/ready) returns one result per sample: angle, cosine,
//    sine, frequency estimate and the d/q voltages. The result sits in an
//    output register, so a stalled receiver holds only that register; the next
//    sample is taken while it waits and finishes into it once it is freed.
//  - The time from acceptance to rsp_valid is set by eleven passes through one
//    shared bit-serial multiplier (one multiplier bit at a time, stopping early
//    on pure sign bits), the CORDIC unit and the load of the output register.
//  - A new sample is taken only once the loop is idle again, after the last
//    result has been loaded into the output register.
//  - APB registers: prop_gain (0x0), integ_gain (0x4), sample_period (0x8),
//    nominal_freq (0xC). Write them only while the loop is idle.
//  - Reset loads the register defaults, clears integrator and phase and sets
//    the stored rotation to angle zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module three_phase_srf_pll #(
   parameter int PHASE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srfpll_pkg::req_type   req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output srfpll_pkg::rsp_type   rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic            [3:0] paddr,
   input  logic           [31:0] pwdata,
   output logic           [31:0] prdata,
   output logic                  pready
);
   import srfpll_pkg::*;

   localparam int S  = SAMPLE_BITS;
   localparam int DW = S + 35;      // d/q accumulation
   localparam int QW = DW - 30;     // rounded d/q
   localparam int EW = QW + 1;      // loop error
   localparam int IW = S + 36;      // integrator sum
   localparam int FW = 34;          // frequency, Q.16 Hz
   localparam int SH = 40 - PHASE_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ALPHA, ST_BETA, ST_CA, ST_SB, ST_CB, ST_SA,
      ST_ETS, ST_KI, ST_KP, ST_W2PI, ST_FTS, ST_CORDIC, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic go_ff, go_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [23:0] prop_gain_ff, integ_gain_ff, sample_period_ff;
   logic [15:0] nominal_freq_ff;

   logic signed [S-1:0]     a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [S+16:0]    alpha_ff, alpha_in;
   logic signed [S+17:0]    beta_ff, beta_in;
   logic signed [DW-1:0]    dsum_ff, dsum_in, qsum_ff, qsum_in;
   logic signed [MUL_A_BITS-1:0] tmp_ff, tmp_in;
   logic signed [31:0]      integ_ff, integ_in, pi_ff, pi_in;
   logic signed [FW-1:0]    freq_ff, freq_in;
   logic [PHASE_BITS-1:0]   accum_ff, accum_in;
   logic signed [15:0]      cos_prev_ff, cos_prev_in, sin_prev_ff, sin_prev_in;

   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [MUL_P_BITS-1:0] mul_product;
   logic                         mul_done, mul_start;
   logic                         cordic_start, cordic_done;
   logic signed [15:0]           cordic_cos, cordic_sin;

   logic signed [S+1:0]   diff_abc;
   logic signed [S:0]     diff_bc;
   logic signed [DW-1:0]  d_rnd, q_rnd;
   logic signed [QW-1:0]  d_val, q_val;
   logic signed [EW-1:0]  err;
   logic signed [MUL_P_BITS-1:0] ki_rnd, kp_rnd, w_rnd;
   logic signed [MUL_P_BITS-27:0] integ_inc;
   logic signed [MUL_P_BITS-5:0]  prop_term;
   logic signed [MUL_A_BITS-1:0]  freq_pi;
   logic signed [IW-1:0]  integ_sum, pi_sum;
   logic signed [FW-1:0]  freq_rnd;
   logic signed [FW-9:0]  freq_hz;
   logic [15:0]           freq_out;
   logic [PHASE_BITS-1:0] phase_inc;
   logic [31:0]           angle32;

   // Saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [IW-1:0] v);
      if (&v[IW-1:31] || ~|v[IW-1:31]) begin
         return v[31:0];
      end
      return v[IW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   // Saturate rounded d/q to the sample range
   function automatic logic signed [S-1:0] sat_sample(input logic signed [QW-1:0] v);
      if (&v[QW-1:S-1] || ~|v[QW-1:S-1]) begin
         return v[S-1:0];
      end
      return v[QW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
   endfunction

   // Configuration registers
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= PROP_GAIN_RST;
         integ_gain_ff    <= INTEG_GAIN_RST;
         sample_period_ff <= SAMPLE_PERIOD_RST;
         nominal_freq_ff  <= NOMINAL_FREQ_RST;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx_type'(paddr[3:2]))
            REG_PROP_GAIN:     prop_gain_ff     <= pwdata[23:0];
            REG_INTEG_GAIN:    integ_gain_ff    <= pwdata[23:0];
            REG_SAMPLE_PERIOD: sample_period_ff <= pwdata[23:0];
            REG_NOMINAL_FREQ:  nominal_freq_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx_type'(paddr[3:2]))
         REG_PROP_GAIN:     prdata = 32'(prop_gain_ff);
         REG_INTEG_GAIN:    prdata = 32'(integ_gain_ff);
         REG_SAMPLE_PERIOD: prdata = 32'(sample_period_ff);
         REG_NOMINAL_FREQ:  prdata = 32'(nominal_freq_ff);
         default:           prdata = '0;
      endcase
   end

   // Clarke differences
   assign diff_abc = (S+2)'(a_ff) + (S+2)'(a_ff) - (S+2)'(b_ff) - (S+2)'(c_ff);
   assign diff_bc  = (S+1)'(b_ff) - (S+1)'(c_ff);

   // Round d/q to Q.4 and form the loop error
   assign d_rnd = dsum_ff + (DW'(1) << 29);
   assign q_rnd = qsum_ff + (DW'(1) << 29);
   assign d_val = d_rnd[DW-1:30];
   assign q_val = q_rnd[DW-1:30];
   assign err   = -EW'(q_val);

   // Loop filter terms from the multiplier product
   assign ki_rnd    = mul_product + (MUL_P_BITS'(1) << 25);
   assign integ_inc = ki_rnd[MUL_P_BITS-1:26];
   assign integ_sum = IW'(integ_ff) + IW'(integ_inc);
   assign kp_rnd    = mul_product + MUL_P_BITS'(8);
   assign prop_term = kp_rnd[MUL_P_BITS-1:4];
   assign pi_sum    = IW'(prop_term) + IW'(integ_ff);
   assign w_rnd     = mul_product + (MUL_P_BITS'(1) << 31);
   assign freq_pi   = w_rnd[MUL_P_BITS-1:32];

   // Reported frequency, Q8.8 clamped to the unsigned range
   assign freq_rnd = freq_ff + FW'(128);
   assign freq_hz  = freq_rnd[FW-1:8];
   always_comb begin
      if (freq_hz[FW-9]) begin
         freq_out = '0;
      end else if (|freq_hz[FW-10:16]) begin
         freq_out = '1;
      end else begin
         freq_out = freq_hz[15:0];
      end
   end

   // Phase increment: round the 40-bit fraction step to the accumulator width
   if (SH > 0) begin : g_step_round
      logic [MUL_P_BITS-1:0] step_rnd;
      assign step_rnd  = mul_product + (MUL_P_BITS'(1) << (SH - 1));
      assign phase_inc = step_rnd[SH +: PHASE_BITS];
   end else if (SH == 0) begin : g_step_exact
      assign phase_inc = mul_product[PHASE_BITS-1:0];
   end else begin : g_step_wide
      assign phase_inc = {mul_product[PHASE_BITS+SH-1:0], {(-SH){1'b0}}};
   end

   // Top 32 bits of the turn fraction
   if (PHASE_BITS >= 32) begin : g_angle_top
      assign angle32 = accum_ff[PHASE_BITS-1 -: 32];
   end else begin : g_angle_pad
      assign angle32 = {accum_ff, {(32 - PHASE_BITS){1'b0}}};
   end

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ALPHA: begin
            mul_a = MUL_A_BITS'(diff_abc);
            mul_b = ONE_THIRD_Q16;
         end
         ST_BETA: begin
            mul_a = MUL_A_BITS'(diff_bc);
            mul_b = INV_SQRT3_Q16;
         end
         ST_CA: begin
            mul_a = MUL_A_BITS'(alpha_ff);
            mul_b = MUL_B_BITS'(cos_prev_ff);
         end
         ST_SB: begin
            mul_a = MUL_A_BITS'(beta_ff);
            mul_b = MUL_B_BITS'(sin_prev_ff);
         end
         ST_CB: begin
            mul_a = MUL_A_BITS'(beta_ff);
            mul_b = MUL_B_BITS'(cos_prev_ff);
         end
         ST_SA: begin
            mul_a = MUL_A_BITS'(alpha_ff);
            mul_b = MUL_B_BITS'(sin_prev_ff);
         end
         ST_ETS: begin
            mul_a = MUL_A_BITS'(err);
            mul_b = MUL_B_BITS'(sample_period_ff);
         end
         ST_KI: begin
            mul_a = tmp_ff;
            mul_b = MUL_B_BITS'(integ_gain_ff);
         end
         ST_KP: begin
            mul_a = MUL_A_BITS'(err);
            mul_b = MUL_B_BITS'(prop_gain_ff);
         end
         ST_W2PI: begin
            mul_a = MUL_A_BITS'(pi_ff);
            mul_b = INV_TWO_PI_Q32;
         end
         ST_FTS: begin
            mul_a = MUL_A_BITS'(freq_ff);
            mul_b = MUL_B_BITS'(sample_period_ff);
         end
         default: ;
      endcase
   end

   assign mul_start    = go_ff && (state_ff != ST_CORDIC);
   assign cordic_start = go_ff && (state_ff == ST_CORDIC);

   srfpll_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   srfpll_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (angle32),
      .done    (cordic_done),
      .cos_q14 (cordic_cos),
      .sin_q14 (cordic_sin)
   );

   // Sequencer: advance one multiply at a time, then rotate and report
   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      dsum_in      = dsum_ff;
      qsum_in      = qsum_ff;
      tmp_in       = tmp_ff;
      integ_in     = integ_ff;
      pi_in        = pi_ff;
      freq_in      = freq_ff;
      accum_in     = accum_ff;
      cos_prev_in  = cos_prev_ff;
      sin_prev_in  = sin_prev_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_data.phase_a;
               b_in     = req_data.phase_b;
               c_in     = req_data.phase_c;
               state_in = ST_ALPHA;
               go_in    = 1'b1;
            end
         end
         ST_ALPHA: begin
            if (mul_done) begin
               alpha_in = mul_product[S+16:0];
               state_in = ST_BETA;
               go_in    = 1'b1;
            end
         end
         ST_BETA: begin
            if (mul_done) begin
               beta_in  = mul_product[S+17:0];
               state_in = ST_CA;
               go_in    = 1'b1;
            end
         end
         ST_CA: begin
            if (mul_done) begin
               dsum_in  = mul_product[DW-1:0];
               state_in = ST_SB;
               go_in    = 1'b1;
            end
         end
         ST_SB: begin
            if (mul_done) begin
               dsum_in  = dsum_ff + mul_product[DW-1:0];
               state_in = ST_CB;
               go_in    = 1'b1;
            end
         end
         ST_CB: begin
            if (mul_done) begin
               qsum_in  = mul_product[DW-1:0];
               state_in = ST_SA;
               go_in    = 1'b1;
            end
         end
         ST_SA: begin
            if (mul_done) begin
               qsum_in  = qsum_ff - mul_product[DW-1:0];
               state_in = ST_ETS;
               go_in    = 1'b1;
            end
         end
         ST_ETS: begin
            if (mul_done) begin
               tmp_in   = mul_product[MUL_A_BITS+1:2];
               state_in = ST_KI;
               go_in    = 1'b1;
            end
         end
         ST_KI: begin
            if (mul_done) begin
               integ_in = sat32(integ_sum);
               state_in = ST_KP;
               go_in    = 1'b1;
            end
         end
         ST_KP: begin
            if (mul_done) begin
               pi_in    = sat32(pi_sum);
               state_in = ST_W2PI;
               go_in    = 1'b1;
            end
         end
         ST_W2PI: begin
            if (mul_done) begin
               freq_in  = FW'(freq_pi) + FW'({nominal_freq_ff, 8'h00});
               state_in = ST_FTS;
               go_in    = 1'b1;
            end
         end
         ST_FTS: begin
            if (mul_done) begin
               accum_in = accum_ff + phase_inc;
               state_in = ST_CORDIC;
               go_in    = 1'b1;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               cos_prev_in = cordic_cos;
               sin_prev_in = cordic_sin;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.angle    = angle32[31:16];
               rsp_data_in.cos_out  = cos_prev_ff;
               rsp_data_in.sin_out  = sin_prev_ff;
               rsp_data_in.freq_est = freq_out;
               rsp_data_in.volt_d   = OUT_BITS'(sat_sample(d_val));
               rsp_data_in.volt_q   = OUT_BITS'(sat_sample(q_val));
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         accum_ff     <= '0;
         cos_prev_ff  <= COS_ZERO_Q14;
         sin_prev_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         accum_ff     <= accum_in;
         cos_prev_ff  <= cos_prev_in;
         sin_prev_ff  <= sin_prev_in;
      end
      rsp_data_ff <= rsp_data_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      alpha_ff    <= alpha_in;
      beta_ff     <= beta_in;
      dsum_ff     <= dsum_in;
      qsum_ff     <= qsum_in;
      tmp_ff      <= tmp_in;
      pi_ff       <= pi_in;
      freq_ff     <= freq_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted transaction starts the multiplier on the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> mul_start && !req_ready)
      else $error("accepted transaction did not start the sequence");

   // Multiplier results only arrive while a multiply step is active
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff != ST_IDLE && state_ff != ST_CORDIC && state_ff != ST_FINISH)
      else $error("multiplier result outside a multiply step");

   // CORDIC results only arrive in the rotation step
   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_CORDIC)
      else $error("cordic result outside the rotation step");

   // Stored rotation stays within +-1.0
   a_rotation_range: assert property (@(posedge clock) disable iff (reset)
      cos_prev_ff <= 16'sd16384 && cos_prev_ff >= -16'sd16384 &&
      sin_prev_ff <= 16'sd16384 && sin_prev_ff >= -16'sd16384)
      else $error("stored cosine or sine out of range");

endmodule

// File: src/srfpll_mul.sv
// ----------------------------------------------------------------------------
// srfpll_mul: shared bit-serial signed multiplier
// Consumes the multiplier one bit per cycle, LSB first, and stops as soon as
// the remaining bits are pure sign (all zeros or all ones).
// ----------------------------------------------------------------------------
module srfpll_mul (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [srfpll_pkg::MUL_A_BITS-1:0] op_a,
   input  logic signed [srfpll_pkg::MUL_B_BITS-1:0] op_b,
   output logic                                    done,
   output logic signed [srfpll_pkg::MUL_P_BITS-1:0] product
);
   import srfpll_pkg::*;

   logic signed [MUL_P_BITS-1:0] acc_ff, acc_in;
   logic signed [MUL_P_BITS-1:0] mcand_ff, mcand_in;
   logic signed [MUL_B_BITS-1:0] mplier_ff, mplier_in;
   logic                         run_ff, run_in;
   logic                         done_ff, done_in;

   // Step one multiplier bit per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = MUL_P_BITS'(op_a);
         mplier_in = op_b;
         run_in    = 1'b1;
      end else if (run_ff) begin
         if (mplier_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else if (mplier_ff == '1) begin
            // remaining value is -1 at this weight
            acc_in  = acc_ff - mcand_ff;
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >>> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: src/srfpll_cordic.sv
// ----------------------------------------------------------------------------
// srfpll_cordic: iterative rotation-mode CORDIC
// Folds the angle into a half turn around zero, runs one micro-rotation per
// cycle and rounds cosine and sine to Q1.14.
// ----------------------------------------------------------------------------
module srfpll_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic        [31:0] angle,
   output logic               done,
   output logic signed [15:0] cos_q14,
   output logic signed [15:0] sin_q14
);
   import srfpll_pkg::*;

   localparam logic signed [CORDIC_BITS-1:0] QUARTER = CORDIC_BITS'(64'sd1 <<< 30);
   localparam logic signed [CORDIC_BITS-1:0] HALF    = CORDIC_BITS'(64'sd1 <<< 31);

   logic signed [CORDIC_BITS-1:0] x_ff, x_in, y_ff, y_in, rel_ff, rel_in;
   logic                   [3:0] idx_ff, idx_in;
   logic                         run_ff, run_in, fin_ff, fin_in, neg_ff, neg_in;
   logic                         done_ff, done_in;
   logic signed           [15:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [CORDIC_BITS-1:0] rel0, xs, ys, atan_ext;

   // Round to Q1.14 and clamp to +-1.0
   function automatic logic signed [15:0] to_q14(input logic signed [CORDIC_BITS-1:0] v);
      logic signed [CORDIC_BITS-1:0] r;
      logic signed [CORDIC_BITS-17:0] q;
      r = v + CORDIC_BITS'(32768);
      q = r[CORDIC_BITS-1:16];
      if (q > 18'sd16384) begin
         return 16'sd16384;
      end else if (q < -18'sd16384) begin
         return -16'sd16384;
      end
      return q[15:0];
   endfunction

   assign rel0     = CORDIC_BITS'($signed(angle));
   assign xs       = x_ff >>> idx_ff;
   assign ys       = y_ff >>> idx_ff;
   assign atan_ext = CORDIC_BITS'(atan_turn(idx_ff));

   // Fold, rotate, finish
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      rel_in  = rel_ff;
      idx_in  = idx_ff;
      run_in  = run_ff;
      fin_in  = 1'b0;
      neg_in  = neg_ff;
      done_in = 1'b0;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (start) begin
         x_in   = CORDIC_GAIN_Q30;
         y_in   = '0;
         idx_in = '0;
         run_in = 1'b1;
         neg_in = 1'b0;
         rel_in = rel0;
         if (rel0 > QUARTER) begin
            rel_in = rel0 - HALF;
            neg_in = 1'b1;
         end else if (rel0 < -QUARTER) begin
            rel_in = rel0 + HALF;
            neg_in = 1'b1;
         end
      end else if (run_ff) begin
         if (!rel_ff[CORDIC_BITS-1]) begin
            x_in   = x_ff - ys;
            y_in   = y_ff + xs;
            rel_in = rel_ff - atan_ext;
         end else begin
            x_in   = x_ff + ys;
            y_in   = y_ff - xs;
            rel_in = rel_ff + atan_ext;
         end
         idx_in = idx_ff + 4'd1;
         if (idx_ff == 4'(CORDIC_STEPS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         cos_in  = neg_ff ? -to_q14(x_ff) : to_q14(x_ff);
         sin_in  = neg_ff ? -to_q14(y_ff) : to_q14(y_ff);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      rel_ff <= rel_in;
      idx_ff <= idx_in;
      neg_ff <= neg_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign done    = done_ff;
   assign cos_q14 = cos_ff;
   assign sin_q14 = sin_ff;

endmodule
